>>> sv/rgbhsv_pkg.sv
`timescale 1ns / 1ps

package rgbhsv_pkg;

	localparam int CH_W      = 8;
	localparam int DIV_STEP  = 2;

	localparam logic [7:0] HUE_SCALE  = 8'd43;
	localparam logic [7:0] HUE_BASE_R = 8'd0;
	localparam logic [7:0] HUE_BASE_G = 8'd85;
	localparam logic [7:0] HUE_BASE_B = 8'd171;

	typedef enum logic [1:0] {
		CH_RED   = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE  = 2'd2
	} chan_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [CH_W-1:0] hue;
		logic [CH_W-1:0] saturation;
		logic [CH_W-1:0] brightness;
	} hsv_t;

	// values that ride alongside the divider stages
	typedef struct packed {
		logic [CH_W-1:0] mx;
		logic            rng_zero;
		logic            neg;
		chan_t           sel;
	} side_t;

	function automatic logic [CH_W-1:0] hue_base(input chan_t sel);
		logic [CH_W-1:0] b;
		case (sel)
			CH_RED:   b = HUE_BASE_R;
			CH_GREEN: b = HUE_BASE_G;
			CH_BLUE:  b = HUE_BASE_B;
			default:  b = HUE_BASE_R;
		endcase
		return b;
	endfunction

endpackage

>>> sv/rgbhsv_stream_if.sv
`timescale 1ns / 1ps

interface rgbhsv_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> sv/rgb_to_hsv_8bit.sv
`timescale 1ns / 1ps

// RGB to HSV conversion of 8-bit pixels, fully pipelined.
//
// pixel  : sink channel, valid/ready, payload red/green/blue.
// result : source channel, valid/ready, payload hue/saturation/brightness.
// A transfer happens on a rising clk edge with valid and ready both high.
//
// Throughput is one pixel per clock while result.ready is high. The pipeline
// has one stage for max/min, one for the scaling multiplies, 8/DIV_STEP stages
// of the two restoring dividers (saturation and hue run side by side), and
// the output register.
//
// arst_n clears all stage valid bits; the pipeline comes up empty.
// When result.ready is low, stages back-pressure one by one: empty stages
// still fill, so pixel.ready drops only once every stage holds a pixel.
// No pixel is dropped or duplicated under any stall pattern.
module rgb_to_hsv_8bit #(
	parameter int DIV_STEP = rgbhsv_pkg::DIV_STEP
) (
	input  logic            clk,
	input  logic            arst_n,
	rgbhsv_stream_if.sink   pixel,
	rgbhsv_stream_if.source result
);

	localparam int CH_W = rgbhsv_pkg::CH_W;
	localparam int NDIV = CH_W / DIV_STEP;
	localparam int NS   = NDIV + 3;

	logic [NS-1:0] vld_s;
	logic [NS:0]   rdy;
	logic [NS-1:0] vld_in;

	always_comb begin
		rdy[NS] = result.ready;
		for (int k = NS - 1; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	assign vld_in = {vld_s[NS-2:0], pixel.valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_in[k];
				end
			end
		end
	end

	assign pixel.ready  = rdy[0];
	assign result.valid = vld_s[NS-1];

	// stage 1: max, min, winning channel, signed difference
	logic [CH_W-1:0]   r, g, b;
	logic [CH_W-1:0]   mx, mn, da, db;
	rgbhsv_pkg::chan_t sel;

	assign r = pixel.data.red;
	assign g = pixel.data.green;
	assign b = pixel.data.blue;

	always_comb begin
		if (r >= g && r >= b) begin
			sel = rgbhsv_pkg::CH_RED;
			mx  = r;
			da  = g;
			db  = b;
		end else if (g >= b) begin
			sel = rgbhsv_pkg::CH_GREEN;
			mx  = g;
			da  = b;
			db  = r;
		end else begin
			sel = rgbhsv_pkg::CH_BLUE;
			mx  = b;
			da  = r;
			db  = g;
		end
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
	end

	logic [CH_W-1:0]   mx_s1, rng_s1, mag_s1;
	logic              neg_s1;
	rgbhsv_pkg::chan_t sel_s1;

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			mx_s1  <= mx;
			rng_s1 <= mx - mn;
			neg_s1 <= da < db;
			mag_s1 <= (da < db) ? (db - da) : (da - db);
			sel_s1 <= sel;
		end
	end

	// stage 2: numerators 255*range and 43*|difference|
	logic [2*CH_W-1:0] sat_num_s2, hue_num_s2;
	logic [CH_W-1:0]   rng_s2;
	rgbhsv_pkg::side_t side_s2;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			sat_num_s2       <= {rng_s1, {CH_W{1'b0}}} - {{CH_W{1'b0}}, rng_s1};
			hue_num_s2       <= {{CH_W{1'b0}}, mag_s1} *
				{{CH_W{1'b0}}, rgbhsv_pkg::HUE_SCALE};
			rng_s2           <= rng_s1;
			side_s2.mx       <= mx_s1;
			side_s2.rng_zero <= (rng_s1 == '0);
			side_s2.neg      <= neg_s1;
			side_s2.sel      <= sel_s1;
		end
	end

	// divider stages
	logic [CH_W-1:0] sat_quo, hue_quo;

	rgbhsv_div #(
		.DEN_W (CH_W),
		.Q_W   (CH_W),
		.STEP  (DIV_STEP)
	) u_sat_div (
		.clk (clk),
		.adv (rdy[NDIV+1:2]),
		.num (sat_num_s2),
		.den (side_s2.mx),
		.quo (sat_quo)
	);

	rgbhsv_div #(
		.DEN_W (CH_W),
		.Q_W   (CH_W),
		.STEP  (DIV_STEP)
	) u_hue_div (
		.clk (clk),
		.adv (rdy[NDIV+1:2]),
		.num (hue_num_s2),
		.den (rng_s2),
		.quo (hue_quo)
	);

	rgbhsv_pkg::side_t side_s [NDIV];

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			side_s[0] <= side_s2;
		end
		for (int j = 1; j < NDIV; j++) begin
			if (rdy[j+2]) begin
				side_s[j] <= side_s[j-1];
			end
		end
	end

	// output stage: signed hue offset added to base, wraps mod 256
	rgbhsv_pkg::side_t sd;
	logic [CH_W-1:0]   hue_off;
	rgbhsv_pkg::hsv_t  res_d, res_q;

	assign sd      = side_s[NDIV-1];
	assign hue_off = sd.neg ? (~hue_quo + 1'b1) : hue_quo;

	always_comb begin
		res_d.brightness = sd.mx;
		res_d.saturation = (sd.mx == '0) ? '0 : sat_quo;
		res_d.hue        = sd.rng_zero ? '0 : (rgbhsv_pkg::hue_base(sd.sel) + hue_off);
	end

	always_ff @(posedge clk) begin
		if (rdy[NS-1]) begin
			res_q <= res_d;
		end
	end

	assign result.data = res_q;

`ifndef ASSERT_OFF
	a_black_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.brightness == '0
		|-> result.data.saturation == '0 && result.data.hue == '0)
		else $error("black pixel with nonzero hue or saturation");

	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.saturation == '0 |-> result.data.hue == '0)
		else $error("zero saturation with nonzero hue");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel.ready |-> result.valid && !result.ready)
		else $error("input stalled while output side can move");
`endif

endmodule

>>> sv/rgbhsv_div.sv
`timescale 1ns / 1ps

module rgbhsv_div #(
	parameter int DEN_W = rgbhsv_pkg::CH_W,
	parameter int Q_W   = rgbhsv_pkg::CH_W,
	parameter int STEP  = rgbhsv_pkg::DIV_STEP
) (
	input  logic                   clk,
	input  logic [Q_W/STEP-1:0]    adv,
	input  logic [DEN_W+Q_W-1:0]   num,
	input  logic [DEN_W-1:0]       den,
	output logic [Q_W-1:0]         quo
);

	localparam int NST = Q_W / STEP;

	logic [DEN_W-1:0] rem_s [NST];
	logic [Q_W-1:0]   low_s [NST];
	logic [DEN_W-1:0] den_s [NST];
	logic [Q_W-1:0]   quo_s [NST];

	// restoring division, STEP quotient bits per stage; the upper numerator
	// half is known to be below the divisor, so the quotient fits in Q_W bits
	genvar k;
	generate
		for (k = 0; k < NST; k++) begin : g_stage
			logic [DEN_W-1:0] rem_i, rem_o;
			logic [Q_W-1:0]   low_i, low_o;
			logic [DEN_W-1:0] den_i;
			logic [Q_W-1:0]   quo_i, quo_o;

			if (k == 0) begin : g_first
				assign rem_i = num[DEN_W+Q_W-1:Q_W];
				assign low_i = num[Q_W-1:0];
				assign den_i = den;
				assign quo_i = '0;
			end else begin : g_next
				assign rem_i = rem_s[k-1];
				assign low_i = low_s[k-1];
				assign den_i = den_s[k-1];
				assign quo_i = quo_s[k-1];
			end

			always_comb begin
				logic [DEN_W:0] trial;
				rem_o = rem_i;
				low_o = low_i;
				quo_o = quo_i;
				trial = '0;
				for (int i = 0; i < STEP; i++) begin
					trial = {rem_o, low_o[Q_W-1]};
					low_o = {low_o[Q_W-2:0], 1'b0};
					if (trial >= {1'b0, den_i}) begin
						trial = trial - {1'b0, den_i};
						quo_o = {quo_o[Q_W-2:0], 1'b1};
					end else begin
						quo_o = {quo_o[Q_W-2:0], 1'b0};
					end
					rem_o = trial[DEN_W-1:0];
				end
			end

			always_ff @(posedge clk) begin
				if (adv[k]) begin
					rem_s[k] <= rem_o;
					low_s[k] <= low_o;
					den_s[k] <= den_i;
					quo_s[k] <= quo_o;
				end
			end
		end
	endgenerate

	assign quo = quo_s[NST-1];

endmodule
